// ===== sv/lcdrfp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the LCD reply frame parser.
// Depends on nothing; used by every module of the block.
package lcdrfp_pkg;

  localparam int MAX_PAYLOAD = 128;
  localparam int POS_W = $clog2(MAX_PAYLOAD);
  localparam int REM_W = $clog2(MAX_PAYLOAD + 1);
  localparam int LEN_W = 9;
  localparam int IDX_W = 7;

  typedef enum logic [2:0] {
    REG_HEADER_FIRST      = 3'd0,
    REG_HEADER_SECOND     = 3'd1,
    REG_READ_REGISTER     = 3'd2,
    REG_READ_VARIABLE     = 3'd3,
    REG_SINGLE_HEADER     = 3'd4,
    REG_UNKNOWN_CMD_WAITS = 3'd5
  } cfg_idx_t;

  localparam logic [7:0] RST_HEADER_FIRST  = 8'h5A;
  localparam logic [7:0] RST_HEADER_SECOND = 8'hA5;
  localparam logic [7:0] RST_READ_REGISTER = 8'h81;
  localparam logic [7:0] RST_READ_VARIABLE = 8'h83;

  typedef struct packed {
    logic [7:0] header_first;
    logic [7:0] header_second;
    logic [7:0] read_register_code;
    logic [7:0] read_variable_code;
    logic       single_header_mode;
    logic       unknown_command_waits;
    logic       mode_write;
  } cfg_t;

  typedef struct packed {
    logic [15:0]      item_address;
    logic             is_register;
    logic [IDX_W-1:0] byte_index;
    logic [7:0]       payload_byte;
    logic             last_byte;
  } result_t;

endpackage

// ===== sv/lcdrfp_cfg.sv =====
`timescale 1ns / 1ps
// Configuration register bank of the LCD reply frame parser.
// Depends on lcdrfp_pkg.
module lcdrfp_cfg (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [7:0]          cfg_data,
  output lcdrfp_pkg::cfg_t    cfg
);

  logic [7:0] header_first;
  logic [7:0] header_second;
  logic [7:0] read_register_code;
  logic [7:0] read_variable_code;
  logic       single_header_mode;
  logic       unknown_command_waits;
  logic       wr;

  assign cfg_ready = 1'b1;
  assign wr = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_first          <= lcdrfp_pkg::RST_HEADER_FIRST;
      header_second         <= lcdrfp_pkg::RST_HEADER_SECOND;
      read_register_code    <= lcdrfp_pkg::RST_READ_REGISTER;
      read_variable_code    <= lcdrfp_pkg::RST_READ_VARIABLE;
      single_header_mode    <= 1'b0;
      unknown_command_waits <= 1'b0;
    end else if (wr) begin
      case (lcdrfp_pkg::cfg_idx_t'(cfg_index))
        lcdrfp_pkg::REG_HEADER_FIRST:      header_first <= cfg_data;
        lcdrfp_pkg::REG_HEADER_SECOND:     header_second <= cfg_data;
        lcdrfp_pkg::REG_READ_REGISTER:     read_register_code <= cfg_data;
        lcdrfp_pkg::REG_READ_VARIABLE:     read_variable_code <= cfg_data;
        lcdrfp_pkg::REG_SINGLE_HEADER:     single_header_mode <= cfg_data[0];
        lcdrfp_pkg::REG_UNKNOWN_CMD_WAITS: unknown_command_waits <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.header_first          = header_first;
    cfg.header_second         = header_second;
    cfg.read_register_code    = read_register_code;
    cfg.read_variable_code    = read_variable_code;
    cfg.single_header_mode    = single_header_mode;
    cfg.unknown_command_waits = unknown_command_waits;
    cfg.mode_write = wr && (cfg_index == lcdrfp_pkg::REG_SINGLE_HEADER);
  end

endmodule

// ===== sv/lcdrfp_fsm.sv =====
`timescale 1ns / 1ps
// Input byte register and frame state machine of the LCD reply frame parser.
// Depends on lcdrfp_pkg.
module lcdrfp_fsm (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            rx_byte,
  input  lcdrfp_pkg::cfg_t      cfg,
  input  logic                  room,
  output logic                  push,
  output lcdrfp_pkg::result_t   result
);

  typedef enum logic [6:0] {
    PH_IDLE = 7'b0000001,
    PH_HEAD = 7'b0000010,
    PH_LEN  = 7'b0000100,
    PH_CMD  = 7'b0001000,
    PH_REG  = 7'b0010000,
    PH_VAR  = 7'b0100000,
    PH_DATA = 7'b1000000
  } phase_t;

  logic                          s1_valid;
  logic [7:0]                    s1_byte;
  logic                          take;

  phase_t                        phase, phase_next;
  logic [lcdrfp_pkg::POS_W-1:0]  position, position_next;
  logic [lcdrfp_pkg::REM_W-1:0]  remaining, remaining_next;
  logic [15:0]                   address_reg, address_reg_next;
  logic                          register_flag, register_flag_next;

  logic [lcdrfp_pkg::LEN_W-1:0]  len;
  logic                          len_bad;
  logic                          last;
  logic [lcdrfp_pkg::POS_W+lcdrfp_pkg::IDX_W-1:0] pos_wide;

  assign take     = s1_valid && room;
  assign in_stall = s1_valid && !room;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= (in_valid && !in_stall) || (s1_valid && !take);
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte <= rx_byte;
    end
  end

  always_comb begin
    if (phase == PH_REG) begin
      len = {1'b0, s1_byte};
    end else begin
      len = {s1_byte, 1'b0};
    end
    len_bad  = (len == '0) ||
               (len > lcdrfp_pkg::LEN_W'(lcdrfp_pkg::MAX_PAYLOAD));
    last     = (remaining <= lcdrfp_pkg::REM_W'(1));
    pos_wide = {{lcdrfp_pkg::IDX_W{1'b0}}, position};
  end

  always_comb begin
    phase_next         = phase;
    position_next      = position;
    remaining_next     = remaining;
    address_reg_next   = address_reg;
    register_flag_next = register_flag;
    push               = 1'b0;

    result.item_address = address_reg;
    result.is_register  = register_flag;
    result.byte_index   = pos_wide[lcdrfp_pkg::IDX_W-1:0];
    result.payload_byte = s1_byte;
    result.last_byte    = last;

    if (cfg.mode_write) begin
      phase_next     = PH_IDLE;
      position_next  = '0;
      remaining_next = '0;
    end else if (take) begin
      case (phase)
        PH_IDLE: begin
          if (s1_byte == cfg.header_first) begin
            phase_next = PH_HEAD;
          end
        end
        PH_HEAD: begin
          if (cfg.single_header_mode) begin
            if (s1_byte == cfg.read_variable_code) begin
              register_flag_next = 1'b0;
              position_next      = '0;
              phase_next         = PH_VAR;
            end else begin
              phase_next     = PH_IDLE;
              position_next  = '0;
              remaining_next = '0;
            end
          end else if (s1_byte == cfg.header_second) begin
            phase_next = PH_LEN;
          end else begin
            phase_next     = PH_IDLE;
            position_next  = '0;
            remaining_next = '0;
          end
        end
        PH_LEN: begin
          phase_next = PH_CMD;
        end
        PH_CMD: begin
          position_next = '0;
          if (s1_byte == cfg.read_register_code) begin
            register_flag_next = 1'b1;
            phase_next         = PH_REG;
          end else if (s1_byte == cfg.read_variable_code) begin
            register_flag_next = 1'b0;
            phase_next         = PH_VAR;
          end else if (!cfg.unknown_command_waits) begin
            phase_next     = PH_IDLE;
            remaining_next = '0;
          end
        end
        PH_REG, PH_VAR: begin
          if (position == '0) begin
            address_reg_next = {8'h00, s1_byte};
            position_next    = lcdrfp_pkg::POS_W'(1);
          end else if (phase == PH_VAR && position == lcdrfp_pkg::POS_W'(1)) begin
            address_reg_next = {address_reg[7:0], s1_byte};
            position_next    = lcdrfp_pkg::POS_W'(2);
          end else if (len_bad) begin
            phase_next     = PH_IDLE;
            position_next  = '0;
            remaining_next = '0;
          end else begin
            remaining_next = len[lcdrfp_pkg::REM_W-1:0];
            position_next  = '0;
            phase_next     = PH_DATA;
          end
        end
        PH_DATA: begin
          push = 1'b1;
          if (last) begin
            phase_next     = PH_IDLE;
            position_next  = '0;
            remaining_next = '0;
          end else begin
            remaining_next = remaining - lcdrfp_pkg::REM_W'(1);
            position_next  = position + lcdrfp_pkg::POS_W'(1);
          end
        end
        default: begin
          phase_next     = PH_IDLE;
          position_next  = '0;
          remaining_next = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      position      <= '0;
      remaining     <= '0;
      address_reg   <= '0;
      register_flag <= 1'b0;
    end else begin
      phase         <= phase_next;
      position      <= position_next;
      remaining     <= remaining_next;
      address_reg   <= address_reg_next;
      register_flag <= register_flag_next;
    end
  end

endmodule

// ===== sv/lcdrfp_outbuf.sv =====
`timescale 1ns / 1ps
// Two-entry result register with skid slot for the LCD reply frame parser.
// Depends on lcdrfp_pkg.
module lcdrfp_outbuf (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  lcdrfp_pkg::result_t   push_data,
  output logic                  room,
  output logic                  out_valid,
  input  logic                  out_stall,
  output lcdrfp_pkg::result_t   head
);

  lcdrfp_pkg::result_t entry [2];
  logic [1:0]          cnt, cnt_next;
  logic                wr_ptr;
  logic                rd_ptr;
  logic                pop;

  assign room      = (cnt != 2'd2);
  assign out_valid = (cnt != 2'd0);
  assign pop       = out_valid && !out_stall;
  assign head      = entry[rd_ptr];

  always_comb begin
    cnt_next = cnt;
    if (push && !pop) begin
      cnt_next = cnt + 2'd1;
    end else if (pop && !push) begin
      cnt_next = cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      cnt <= cnt_next;
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== sv/lcd_reply_frame_parser.sv =====
`timescale 1ns / 1ps
// Top level of the LCD reply frame parser.
// Depends on lcdrfp_pkg, lcdrfp_cfg, lcdrfp_fsm and lcdrfp_outbuf.
//
// Takes one received display byte per request and emits one result per
// payload byte of a register read or variable read reply, with the reply
// address, register/variable flag, byte index and last mark. Bytes are taken
// at one per cycle while the result buffer has room: each byte passes an input
// register, one step of the frame state machine, and a two-entry result buffer;
// a payload byte is held in the input register and then in a result entry,
// from which it is presented at the output. Input stalls only when both result
// entries are waiting. Register writes are taken in any cycle (cfg_ready is
// always high); writing single_header_mode returns the parser to idle.
module lcd_reply_frame_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] item_address,
  output logic        is_register,
  output logic [6:0]  byte_index,
  output logic [7:0]  payload_byte,
  output logic        last_byte,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  lcdrfp_pkg::cfg_t    cfg;
  lcdrfp_pkg::result_t result;
  lcdrfp_pkg::result_t head;
  logic                room;
  logic                push;

  lcdrfp_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lcdrfp_fsm u_fsm (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .rx_byte  (rx_byte),
    .cfg      (cfg),
    .room     (room),
    .push     (push),
    .result   (result)
  );

  lcdrfp_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (result),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign item_address = head.item_address;
  assign is_register  = head.is_register;
  assign byte_index   = head.byte_index;
  assign payload_byte = head.payload_byte;
  assign last_byte    = head.last_byte;

endmodule
